>>> rtl/wtsq_pkg.sv
`timescale 1ns / 1ps
package wtsq_pkg;

    localparam int MEM_DEPTH = 64;
    localparam int IDX_W     = 6;

    localparam logic [1:0] CFG_TARGET_SUM   = 2'd0;
    localparam logic [1:0] CFG_KEEP_NONZERO = 2'd1;

    typedef struct packed {
        logic signed [31:0] weight;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [5:0]         element_index;
        logic signed [15:0] qweight;
        logic [23:0]        achieved_sum;
        logic               last_out;
    } t_out;

    // read request into the quantiser pipeline
    typedef struct packed {
        logic             rd;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_qreq;

    // one quantised magnitude out of the pipeline
    typedef struct packed {
        logic        vld;
        logic        last;
        logic        neg;
        logic [31:0] mag;
    } t_qres;

    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [39:0]  den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/wtsq_div.sv
`timescale 1ns / 1ps
module wtsq_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wtsq_pkg::t_div_req  i_req,
    output wtsq_pkg::t_div_rsp  o_rsp
);
    import wtsq_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [39:0] r_rem;
    logic [39:0] r_den;
    logic [63:0] r_lo;
    logic [63:0] r_quot;

    logic [40:0] rs;
    logic [40:0] sub;
    logic        ge;
    logic        sat;

    assign rs  = {r_rem, r_lo[63]};
    assign sub = rs - {1'b0, r_den};
    assign ge  = rs >= {1'b0, r_den};
    // quotient would not fit in 64 bits
    assign sat = (i_req.den == 40'd0) || (i_req.num[127:64] >= {24'd0, i_req.den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= !sat;
                r_done <= sat;
            end else if (r_busy && r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt  <= 6'd0;
            r_rem  <= i_req.num[103:64];
            r_lo   <= i_req.num[63:0];
            r_den  <= i_req.den;
            r_quot <= {64{1'b1}};
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 6'd1;
            r_rem  <= ge ? sub[39:0] : rs[39:0];
            r_lo   <= {r_lo[62:0], 1'b0};
            r_quot <= {r_quot[62:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> rtl/wtsq_quant.sv
`timescale 1ns / 1ps
module wtsq_quant #(
    parameter logic [31:0] ELEMENT_MAX = 32'd32767
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [wtsq_pkg::IDX_W-1:0] i_waddr,
    input  logic [31:0]                i_wdata,
    input  wtsq_pkg::t_qreq            i_req,
    input  logic [63:0]                i_scale,
    input  logic                       i_keep_nonzero,
    output wtsq_pkg::t_qres            o_res
);
    import wtsq_pkg::*;

    logic [31:0] r_mem [MEM_DEPTH];
    logic [31:0] r_rdata;
    logic        r_v1, r_l1;
    logic [31:0] r_a;
    logic        r_v2, r_l2, r_n2;
    logic [63:0] r_p0, r_p1;
    logic        r_v3, r_l3, r_n3, r_z3;
    logic        r_v4, r_l4, r_n4;
    logic [31:0] r_mag4;

    logic [95:0] sum96;
    logic [47:0] hi48;
    logic [31:0] mag;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_req.rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // magnitude, then the 64x32 product as two 32x32 halves, then round and clamp
    always_ff @(posedge i_clk) begin
        r_l1   <= i_req.last;
        r_a    <= r_rdata[31] ? (~r_rdata + 32'd1) : r_rdata;
        r_n2   <= r_rdata[31];
        r_l2   <= r_l1;
        r_p0   <= i_scale[31:0] * r_a;
        r_p1   <= i_scale[63:32] * r_a;
        r_z3   <= (r_a == 32'd0);
        r_n3   <= r_n2;
        r_l3   <= r_l2;
        r_mag4 <= mag;
        r_n4   <= r_n3;
        r_l4   <= r_l3;
    end

    always_comb begin
        sum96 = {r_p1, 32'd0} + {32'd0, r_p0} + 96'h8000_0000_0000;
        hi48  = sum96[95:48];
        if (r_z3) begin
            mag = 32'd0;
        end else if (hi48 > {16'd0, ELEMENT_MAX}) begin
            mag = ELEMENT_MAX;
        end else if (hi48 == 48'd0 && i_keep_nonzero) begin
            mag = 32'd1;
        end else begin
            mag = hi48[31:0];
        end
    end

    assign o_res.vld  = r_v4;
    assign o_res.last = r_l4;
    assign o_res.neg  = r_n4;
    assign o_res.mag  = r_mag4;

endmodule

>>> rtl/weight_table_sum_quantizer_top.sv
`timescale 1ns / 1ps
// Weight table sum quantiser. Weights are loaded one per cycle; the item marked last closes the
// table and starts the scale search, during which no input is taken. The search runs three
// 64-step serial divisions for the scale bounds, then quantisation passes over the stored
// table through the single read port of the weight memory: two for the bounds and up to
// ITERATION_LIMIT for the search, plus one more division for the secant step. Results then
// leave one at a time, each weight read and re-quantised at the final scale before the next
// is read, and held while the output stalls. An all-zero table skips the search.
module weight_table_sum_quantizer_top #(
    parameter int          MAX_WEIGHTS     = 64,
    parameter logic [31:0] ELEMENT_MAX     = 32'd32767,
    parameter logic [31:0] SUM_MAX         = 32'd16777215,
    parameter int          ITERATION_LIMIT = 100
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [23:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wtsq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wtsq_pkg::t_out o_out_data
);
    import wtsq_pkg::*;

    typedef enum logic [19:0] {
        S_LOAD      = 20'h00001,
        S_START     = 20'h00002,
        S_DIV_EM    = 20'h00004,
        S_DIV_SM    = 20'h00008,
        S_DIV_LO    = 20'h00010,
        S_BOUND     = 20'h00020,
        S_CLAMP_LO  = 20'h00040,
        S_QLO       = 20'h00080,
        S_QHI       = 20'h00100,
        S_CHECK     = 20'h00200,
        S_SEC_MUL   = 20'h00400,
        S_SEC_ADD   = 20'h00800,
        S_SEC_DIV   = 20'h01000,
        S_SEC_CLAMP = 20'h02000,
        S_QMID      = 20'h04000,
        S_FLIP_D    = 20'h08000,
        S_FLIP_S    = 20'h10000,
        S_OUT_RD    = 20'h20000,
        S_OUT_WAIT  = 20'h40000,
        S_OUT_SEND  = 20'h80000
    } t_state;

    t_state r_state, n_state;

    logic [23:0] r_target;
    logic        r_kn;
    logic [6:0]  r_count;
    logic [39:0] r_abs_sum;
    logic [31:0] r_abs_max;
    logic        r_zero;
    logic [63:0] r_q_em, r_q_sm;
    logic [63:0] r_slo, r_shi, r_smd;
    logic [31:0] r_flo, r_fhi, r_fmd;
    logic [31:0] r_tot;
    logic [6:0]  r_iss;
    logic [6:0]  r_iter;
    logic [63:0] r_ds;
    logic [55:0] r_pa, r_pb;
    logic [87:0] r_prod;
    logic [63:0] r_lowc, r_highc;
    logic        r_up;
    logic [63:0] r_d;
    logic [5:0]  r_oi;
    logic        r_div_wait;
    logic        r_out_vld;
    t_out        r_out;

    logic        in_acc, out_acc, pass;
    logic [31:0] a_in, w_u;
    logic [32:0] nsum;
    logic [31:0] ntot;
    logic [31:0] tgt32;
    logic        mid_stop;
    logic [63:0] sec_val, flip_val, s1;
    logic [63:0] scale;
    t_qreq       qreq;
    t_qres       qres;
    t_div_req    dreq;
    t_div_rsp    drsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_vld && i_out_ready;
    assign pass        = (r_state == S_QLO) || (r_state == S_QHI) || (r_state == S_QMID);
    assign tgt32       = {8'd0, r_target};

    assign w_u  = i_in_data.weight;
    assign a_in = w_u[31] ? (~w_u + 32'd1) : w_u;

    // saturating running sum of magnitudes
    assign nsum = {1'b0, r_tot} + {1'b0, qres.mag};
    assign ntot = (nsum > {1'b0, SUM_MAX}) ? SUM_MAX : nsum[31:0];
    assign mid_stop = (ntot == tgt32) || ((r_iter + 7'd1) >= 7'(ITERATION_LIMIT));

    always_comb begin
        sec_val = r_smd;
        if (sec_val > r_highc) begin
            sec_val = r_highc;
        end
        if (sec_val < r_lowc) begin
            sec_val = r_lowc;
        end
    end

    // flip-and-double: step 2d away from the near bound, or halve towards the far one
    always_comb begin
        s1 = r_up ? r_shi : r_slo;
        if (r_d[63:62] == 2'b00 && r_ds > {r_d[61:0], 2'b00}) begin
            flip_val = r_up ? (r_smd + {r_d[62:0], 1'b0}) : (r_smd - {r_d[62:0], 1'b0});
        end else begin
            flip_val = {1'b0, r_smd[63:1]} + {1'b0, s1[63:1]} + {63'd0, r_smd[0] & s1[0]};
        end
    end

    always_comb begin
        priority if (r_state == S_QLO) begin
            scale = r_slo;
        end else if (r_state == S_QHI) begin
            scale = r_shi;
        end else begin
            scale = r_smd;
        end
    end

    always_comb begin
        qreq.rd   = 1'b0;
        qreq.idx  = r_iss[5:0];
        qreq.last = (r_iss == r_count - 7'd1);
        if (pass) begin
            qreq.rd = (r_iss < r_count);
        end else if (r_state == S_OUT_RD) begin
            qreq.rd   = 1'b1;
            qreq.idx  = r_oi;
            qreq.last = 1'b0;
        end
    end

    always_comb begin
        dreq.start = 1'b0;
        dreq.num   = {40'd0, r_prod};
        dreq.den   = 40'(r_fhi - r_flo);
        priority if (r_state == S_DIV_EM) begin
            dreq.start = !r_div_wait;
            dreq.num   = {47'd0, 1'b0, ELEMENT_MAX, 48'd0};
            dreq.den   = {8'd0, r_abs_max};
        end else if (r_state == S_DIV_SM) begin
            dreq.start = !r_div_wait;
            dreq.num   = {47'd0, 1'b0, SUM_MAX, 48'd0};
            dreq.den   = r_abs_sum;
        end else if (r_state == S_DIV_LO) begin
            dreq.start = !r_div_wait;
            dreq.num   = {56'd0, r_target, 48'd0};
            dreq.den   = r_abs_sum + {9'd0, r_count, 24'd0};
        end else if (r_state == S_SEC_DIV) begin
            dreq.start = !r_div_wait;
        end else begin
            dreq.start = 1'b0;
        end
    end

    wtsq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_rsp   (drsp)
    );

    wtsq_quant #(
        .ELEMENT_MAX (ELEMENT_MAX)
    ) u_quant (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_we           (in_acc && (r_count < 7'(MAX_WEIGHTS))),
        .i_waddr        (r_count[5:0]),
        .i_wdata        (w_u),
        .i_req          (qreq),
        .i_scale        (scale),
        .i_keep_nonzero (r_kn),
        .o_res          (qres)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:      if (in_acc && i_in_data.last) n_state = S_START;
            S_START:     n_state = (r_abs_sum == 40'd0) ? S_OUT_RD : S_DIV_EM;
            S_DIV_EM:    if (drsp.done) n_state = S_DIV_SM;
            S_DIV_SM:    if (drsp.done) n_state = S_DIV_LO;
            S_DIV_LO:    if (drsp.done) n_state = S_BOUND;
            S_BOUND:     n_state = S_CLAMP_LO;
            S_CLAMP_LO:  n_state = S_QLO;
            S_QLO:       if (qres.vld && qres.last) n_state = S_QHI;
            S_QHI:       if (qres.vld && qres.last) n_state = S_CHECK;
            S_CHECK: begin
                if (tgt32 <= r_flo || tgt32 >= r_fhi) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_SEC_MUL;
                end
            end
            S_SEC_MUL:   n_state = S_SEC_ADD;
            S_SEC_ADD:   n_state = S_SEC_DIV;
            S_SEC_DIV:   if (drsp.done) n_state = S_SEC_CLAMP;
            S_SEC_CLAMP: n_state = S_QMID;
            S_QMID: begin
                if (qres.vld && qres.last) begin
                    n_state = mid_stop ? S_OUT_RD : S_FLIP_D;
                end
            end
            S_FLIP_D:    n_state = S_FLIP_S;
            S_FLIP_S:    n_state = S_QMID;
            S_OUT_RD:    n_state = S_OUT_WAIT;
            S_OUT_WAIT:  if (qres.vld) n_state = S_OUT_SEND;
            S_OUT_SEND: begin
                if (out_acc) begin
                    n_state = r_out.last_out ? S_LOAD : S_OUT_RD;
                end
            end
            default:     n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_target   <= 24'd0;
            r_kn       <= 1'b0;
            r_count    <= 7'd0;
            r_abs_sum  <= 40'd0;
            r_abs_max  <= 32'd0;
            r_div_wait <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_TARGET_SUM) begin
                    r_target <= i_cfg_data;
                end else if (i_cfg_index == CFG_KEEP_NONZERO) begin
                    r_kn <= i_cfg_data[0];
                end
            end
            if (in_acc && (r_count < 7'(MAX_WEIGHTS))) begin
                r_count   <= r_count + 7'd1;
                r_abs_sum <= r_abs_sum + {8'd0, a_in};
                if (a_in > r_abs_max) begin
                    r_abs_max <= a_in;
                end
            end
            if (dreq.start) begin
                r_div_wait <= 1'b1;
            end else if (drsp.done) begin
                r_div_wait <= 1'b0;
            end
            if (r_state == S_OUT_WAIT && qres.vld) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
            end
            // table fully delivered: ready for the next one
            if (out_acc && r_out.last_out) begin
                r_count   <= 7'd0;
                r_abs_sum <= 40'd0;
                r_abs_max <= 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_START) begin
            r_zero <= (r_abs_sum == 40'd0);
            r_fmd  <= 32'd0;
            r_oi   <= 6'd0;
        end
        if (drsp.done) begin
            if (r_state == S_DIV_EM) begin
                r_q_em <= drsp.quot;
            end
            if (r_state == S_DIV_SM) begin
                r_q_sm <= drsp.quot;
            end
            if (r_state == S_DIV_LO) begin
                r_slo <= drsp.quot;
            end
            if (r_state == S_SEC_DIV) begin
                r_smd <= r_slo + drsp.quot;
            end
        end
        if (r_state == S_BOUND) begin
            r_shi <= (r_q_em < r_q_sm) ? r_q_em : r_q_sm;
        end
        if (r_state == S_CLAMP_LO) begin
            if (r_slo > r_shi) begin
                r_slo <= r_shi;
            end
            r_iss <= 7'd0;
            r_tot <= 32'd0;
        end
        if (pass) begin
            if (qreq.rd) begin
                r_iss <= r_iss + 7'd1;
            end
            if (qres.vld) begin
                r_tot <= ntot;
                if (qres.last) begin
                    r_iss <= 7'd0;
                    r_tot <= 32'd0;
                    if (r_state == S_QLO) begin
                        r_flo <= ntot;
                    end
                    if (r_state == S_QHI) begin
                        r_fhi <= ntot;
                    end
                    if (r_state == S_QMID) begin
                        r_fmd  <= ntot;
                        r_iter <= r_iter + 7'd1;
                        r_oi   <= 6'd0;
                    end
                end
            end
        end
        if (r_state == S_CHECK) begin
            r_ds <= r_shi - r_slo;
            r_oi <= 6'd0;
            if (tgt32 <= r_flo) begin
                r_smd <= r_slo;
                r_fmd <= r_flo;
            end else if (tgt32 >= r_fhi) begin
                r_smd <= r_shi;
                r_fmd <= r_fhi;
            end
        end
        if (r_state == S_SEC_MUL) begin
            r_pa <= r_ds[31:0] * (r_target - r_flo[23:0]);
            r_pb <= r_ds[63:32] * (r_target - r_flo[23:0]);
        end
        if (r_state == S_SEC_ADD) begin
            r_prod  <= {r_pb, 32'd0} + {32'd0, r_pa};
            r_lowc  <= r_slo + {4'd0, r_ds[63:4]};
            r_highc <= r_shi - {4'd0, r_ds[63:4]};
        end
        if (r_state == S_SEC_CLAMP) begin
            r_smd  <= sec_val;
            r_iter <= 7'd0;
        end
        if (r_state == S_FLIP_D) begin
            r_up <= (r_fmd < tgt32);
            r_d  <= (r_fmd < tgt32) ? (r_smd - r_slo) : (r_shi - r_smd);
        end
        if (r_state == S_FLIP_S) begin
            r_smd <= flip_val;
        end
        if (r_state == S_OUT_WAIT && qres.vld) begin
            r_out.element_index <= r_oi;
            r_out.achieved_sum  <= r_fmd[23:0];
            r_out.last_out      <= ({1'b0, r_oi} + 7'd1) == r_count;
            if (r_zero) begin
                r_out.qweight <= 16'sd0;
            end else if (qres.neg) begin
                r_out.qweight <= ~qres.mag[15:0] + 16'd1;
            end else begin
                r_out.qweight <= qres.mag[15:0];
            end
        end
        if (out_acc && !r_out.last_out) begin
            r_oi <= r_oi + 6'd1;
        end
    end

endmodule

>>> rtl/wtsq_chk.sv
`timescale 1ns / 1ps
module wtsq_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_cfg_valid,
    input logic           o_cfg_ready,
    input logic [1:0]     i_cfg_index,
    input logic [23:0]    i_cfg_data,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input wtsq_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input wtsq_pkg::t_out o_out_data
);
    import wtsq_pkg::*;

    // a result waiting for transfer holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed before transfer");

    // input is never taken while results are being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // closing result of a table frees the input side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last_out |=> o_in_ready)
        else $error("input not ready after final result");

    // a taken result that is not the last is followed by a gap with no result and no input ready
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_out |=> !o_out_valid && !o_in_ready)
        else $error("result sequence broken");

endmodule

bind weight_table_sum_quantizer_top wtsq_chk u_wtsq_chk (.*);
